>>> hw/rtl/tsq_pkg.sv
// ----------------------------------------------------------------------------
// Tetrahedron shape quality package
// Widths, status codes, register indexes and stage payload types that the
// quality pipeline shares between its modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tsq_pkg;

    // Field and datapath widths.
    localparam int COORD_W   = 24;              // Q8.16 coordinate
    localparam int NUM_COORD = 12;              // four vertices, three axes
    localparam int DIFF_W    = COORD_W + 1;     // edge component
    localparam int SQ_W      = 2 * COORD_W;     // squared component, unsigned
    localparam int CP_W      = 2 * DIFF_W - 1;  // cross product term, signed
    localparam int VC_W      = CP_W + 1;        // cross product component
    localparam int VLO_W     = DIFF_W;          // low slice of a component
    localparam int VHI_W     = VC_W - VLO_W;    // high slice, signed
    localparam int PL_W      = DIFF_W + VLO_W + 1;
    localparam int PH_W      = DIFF_W + VHI_W;
    localparam int TRI_W     = VC_W + DIFF_W + 1;
    localparam int VOL_W     = TRI_W + 1;       // six-times volume, signed
    localparam int VMAG_W    = VOL_W - 1;       // volume when known positive
    localparam int EL_W      = SQ_W + 2;        // one squared edge length
    localparam int RSUM_W    = 53;              // sum of squared edges
    localparam int VTHR_W    = 48;
    localparam int LTHR_W    = 32;
    localparam int SQRT_SHIFT = 10;             // root taken of R * 2^10
    localparam int ROOT_W    = 32;
    localparam int SQX_W     = 2 * ROOT_W;
    localparam int RLO_W     = 27;              // low slice of R for R * S
    localparam int RHI_W     = RSUM_W - RLO_W;
    localparam int DPL_W     = RLO_W + ROOT_W;
    localparam int DPH_W     = RHI_W + ROOT_W;
    localparam int DEN_W     = RSUM_W + ROOT_W; // denominator R * S
    localparam int QUO_W     = 32;              // quality, Q0.32
    localparam int NUM_SHIFT = 37;              // numerator is V * 2^37
    localparam int PRE_SHIFT = NUM_SHIFT - QUO_W;

    // Configuration port.
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL_THR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_THR = 8'd1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FLAT  = 2'd1,
        ST_SHORT = 2'd2
    } t_status;

    typedef logic signed [TRI_W-1:0] t_tri;
    typedef logic signed [VOL_W-1:0] t_vol;

    // Payload that rides along the square root stages.
    typedef struct packed {
        logic [VMAG_W-1:0] vmag;
        logic [RSUM_W-1:0] rsum;
        t_status           status;
    } t_side;

endpackage

`default_nettype wire

>>> hw/rtl/tsq_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Computes floor(sqrt(R * 2^10)) one result bit per stage, carrying the
// element payload alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module tsq_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire tsq_pkg::t_side              i_side,
    output logic                             o_valid,
    output logic [tsq_pkg::ROOT_W-1:0]       o_root,
    output tsq_pkg::t_side                   o_side
);

    localparam int N = tsq_pkg::ROOT_W;

    logic                r_valid [1:N];
    logic [N+1:0]        r_rem   [1:N-1];
    logic [N-1:0]        r_root  [1:N];
    tsq_pkg::t_side      r_side  [1:N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic                 valid_in;
            logic [N+1:0]         rem_in;
            logic [N-1:0]         root_in;
            tsq_pkg::t_side       side_in;
            logic [N+3:0]         shifted;
            logic [N+3:0]         trial;
            logic [tsq_pkg::SQX_W-1:0] x;

            if (k == 0) begin : g_first
                assign valid_in = i_valid;
                assign rem_in   = '0;
                assign root_in  = '0;
                assign side_in  = i_side;
            end else begin : g_next
                assign valid_in = r_valid[k];
                assign rem_in   = r_rem[k];
                assign root_in  = r_root[k];
                assign side_in  = r_side[k];
            end

            // Radicand is R shifted up; each stage brings down two bits.
            assign x = {{(tsq_pkg::SQX_W - tsq_pkg::RSUM_W - tsq_pkg::SQRT_SHIFT){1'b0}},
                        side_in.rsum, {tsq_pkg::SQRT_SHIFT{1'b0}}};
            assign shifted = {rem_in, x[tsq_pkg::SQX_W-1-2*k -: 2]};
            assign trial   = {2'b00, root_in, 2'b01};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k+1] <= valid_in;
                end
            end

            // Root bit decision and payload transfer.
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side[k+1] <= side_in;
                    if (shifted >= trial) begin
                        r_root[k+1] <= {root_in[N-2:0], 1'b1};
                    end else begin
                        r_root[k+1] <= {root_in[N-2:0], 1'b0};
                    end
                end
            end

            if (k < N - 1) begin : g_rem
                logic [N+3:0] diff;

                assign diff = shifted - trial;

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        if (shifted >= trial) begin
                            r_rem[k+1] <= diff[N+1:0];
                        end else begin
                            r_rem[k+1] <= shifted[N+1:0];
                        end
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[N];
    assign o_root  = r_root[N];
    assign o_side  = r_side[N];

endmodule

`default_nettype wire

>>> hw/rtl/tsq_div.sv
// ----------------------------------------------------------------------------
// Pipelined quality divider
// Restoring division of V * 2^37 by R * S, one quotient bit per stage, with
// saturation and status override in a final output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsq_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [tsq_pkg::VMAG_W-1:0]  i_vmag,
    input  wire logic [tsq_pkg::DEN_W-1:0]   i_den,
    input  wire tsq_pkg::t_status            i_status,
    output logic                             o_valid,
    output logic [tsq_pkg::QUO_W-1:0]        o_quality,
    output tsq_pkg::t_status                 o_status
);

    localparam int N  = tsq_pkg::QUO_W;
    localparam int DW = tsq_pkg::DEN_W;

    logic                r_valid  [1:N];
    logic [DW-1:0]       r_rem    [1:N-1];
    logic [DW-1:0]       r_den    [1:N-1];
    logic [N-1:0]        r_quo    [1:N];
    logic                r_sat    [1:N];
    tsq_pkg::t_status    r_status [1:N];

    logic                r_out_valid;
    logic [N-1:0]        r_out_quality;
    tsq_pkg::t_status    r_out_status;

    // Upper part of the numerator; a quotient of 2^32 or more saturates.
    logic [DW-1:0] w_rem0;
    logic          w_sat0;

    assign w_rem0 = {{(DW - tsq_pkg::VMAG_W - tsq_pkg::PRE_SHIFT){1'b0}},
                     i_vmag, {tsq_pkg::PRE_SHIFT{1'b0}}};
    assign w_sat0 = (w_rem0 >= i_den);

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic             valid_in;
            logic [DW-1:0]    rem_in;
            logic [DW-1:0]    den_in;
            logic [N-1:0]     quo_in;
            logic             sat_in;
            tsq_pkg::t_status status_in;
            logic [DW:0]      shifted;
            logic             take;

            if (k == 0) begin : g_first
                assign valid_in  = i_valid;
                assign rem_in    = w_rem0;
                assign den_in    = i_den;
                assign quo_in    = '0;
                assign sat_in    = w_sat0;
                assign status_in = i_status;
            end else begin : g_next
                assign valid_in  = r_valid[k];
                assign rem_in    = r_rem[k];
                assign den_in    = r_den[k];
                assign quo_in    = r_quo[k];
                assign sat_in    = r_sat[k];
                assign status_in = r_status[k];
            end

            assign shifted = {rem_in, 1'b0};
            assign take    = (shifted >= {1'b0, den_in});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k+1] <= valid_in;
                end
            end

            // Quotient bit and payload transfer.
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[k+1]    <= {quo_in[N-2:0], take};
                    r_sat[k+1]    <= sat_in;
                    r_status[k+1] <= status_in;
                end
            end

            if (k < N - 1) begin : g_rem
                logic [DW:0] diff;

                assign diff = shifted - {1'b0, den_in};

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_den[k+1] <= den_in;
                        if (take) begin
                            r_rem[k+1] <= diff[DW-1:0];
                        end else begin
                            r_rem[k+1] <= shifted[DW-1:0];
                        end
                    end
                end
            end
        end
    endgenerate

    // Output register: rejected elements read zero, large ones saturate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_status <= r_status[N];
            if (r_status[N] != tsq_pkg::ST_OK) begin
                r_out_quality <= '0;
            end else if (r_sat[N]) begin
                r_out_quality <= '1;
            end else begin
                r_out_quality <= r_quo[N];
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_quality = r_out_quality;
    assign o_status  = r_out_status;

endmodule

`default_nettype wire

>>> hw/rtl/tetrahedron_shape_quality.sv
// Throughput: one element per cycle while the output is not stalled; the 32-stage
// root and 32-stage divider each spend one stage per result bit, so the depth is set
// by those two units. A stall on the output holds the whole pipeline in place.
// Reset clears all valid bits and sets both thresholds to one.
// ----------------------------------------------------------------------------
// Tetrahedron shape quality
// Streams tetrahedra and returns six-times volume over edge sum to the 1.5
// as unsigned Q0.32, with a status for flat and degenerate elements.
// ----------------------------------------------------------------------------
`default_nettype none

module tetrahedron_shape_quality (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input stream.
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z (24 bits each)
    input  wire logic [287:0]                    i_s_axis_tdata,
    // Output stream.
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // quality (32 bits)
    output logic [31:0]                          o_m_axis_tdata,
    // status (2 bits)
    output logic [1:0]                           o_m_axis_tuser,
    // Configuration write channel.
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tsq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tsq_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    localparam int DW = tsq_pkg::DIFF_W;

    logic w_en;

    logic [tsq_pkg::VTHR_W-1:0] r_vol_thr;
    logic [tsq_pkg::LTHR_W-1:0] r_len_thr;

    // Stage 1: edge components (ab, ac, ad, bc, bd, cd, each x y z).
    logic                          r1_valid;
    logic signed [DW-1:0]          r1_e [0:17];
    // Stage 2: cross terms and squares.
    logic                          r2_valid;
    logic signed [tsq_pkg::CP_W-1:0] r2_cp [0:5];
    logic [tsq_pkg::SQ_W-1:0]      r2_sq [0:17];
    logic signed [DW-1:0]          r2_ab [0:2];
    // Stage 3: cross product components and squared edge lengths.
    logic                          r3_valid;
    logic signed [tsq_pkg::VC_W-1:0] r3_v [0:2];
    logic [tsq_pkg::EL_W-1:0]      r3_el [0:5];
    logic signed [DW-1:0]          r3_ab [0:2];
    // Stage 4: partial products of the triple product, edge sum.
    logic                          r4_valid;
    logic signed [tsq_pkg::PL_W-1:0] r4_pl [0:2];
    logic signed [tsq_pkg::PH_W-1:0] r4_ph [0:2];
    logic [tsq_pkg::RSUM_W-1:0]    r4_rsum;
    // Stage 5: triple product terms.
    logic                          r5_valid;
    tsq_pkg::t_tri                 r5_t [0:2];
    logic [tsq_pkg::RSUM_W-1:0]    r5_rsum;
    // Stage 6: six-times volume.
    logic                          r6_valid;
    tsq_pkg::t_vol                 r6_vol;
    logic [tsq_pkg::RSUM_W-1:0]    r6_rsum;
    // Stage 7: classification.
    logic                          r7_valid;
    tsq_pkg::t_side                r7_side;

    // Square root outputs and denominator stages.
    logic                          w_sq_valid;
    logic [tsq_pkg::ROOT_W-1:0]    w_sq_root;
    tsq_pkg::t_side                w_sq_side;
    logic                          r8_valid;
    logic [tsq_pkg::DPL_W-1:0]     r8_dpl;
    logic [tsq_pkg::DPH_W-1:0]     r8_dph;
    tsq_pkg::t_side                r8_side;
    logic                          r9_valid;
    logic [tsq_pkg::DEN_W-1:0]     r9_den;
    logic [tsq_pkg::VMAG_W-1:0]    r9_vmag;
    tsq_pkg::t_status              r9_status;

    logic                          w_out_valid;
    logic [tsq_pkg::QUO_W-1:0]     w_out_quality;
    tsq_pkg::t_status              w_out_status;

    logic signed [tsq_pkg::COORD_W-1:0] w_p [0:11];
    logic                          w_flat;
    logic                          w_short;

    // The pipeline moves whenever the output register is free or drained.
    assign w_en            = !w_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_cfg_ready     = 1'b1;

    // Threshold registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_thr <= tsq_pkg::VTHR_W'(1);
            r_len_thr <= tsq_pkg::LTHR_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tsq_pkg::CFG_VOL_THR: r_vol_thr <= i_cfg_data[tsq_pkg::VTHR_W-1:0];
                tsq_pkg::CFG_LEN_THR: r_len_thr <= i_cfg_data[tsq_pkg::LTHR_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the coordinates.
    genvar g;
    generate
        for (g = 0; g < tsq_pkg::NUM_COORD; g++) begin : g_unpack
            assign w_p[g] = $signed(i_s_axis_tdata[tsq_pkg::COORD_W*g +: tsq_pkg::COORD_W]);
        end
    endgenerate

    // Valid bits of the front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
            r9_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_s_axis_tvalid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
            r8_valid <= w_sq_valid;
            r9_valid <= r8_valid;
        end
    end

    // Stage 1: edge vectors as differences of vertices.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r1_e[a]      <= DW'(w_p[3 + a]) - DW'(w_p[a]);      // ab
                r1_e[3 + a]  <= DW'(w_p[6 + a]) - DW'(w_p[a]);      // ac
                r1_e[6 + a]  <= DW'(w_p[9 + a]) - DW'(w_p[a]);      // ad
                r1_e[9 + a]  <= DW'(w_p[6 + a]) - DW'(w_p[3 + a]);  // bc
                r1_e[12 + a] <= DW'(w_p[9 + a]) - DW'(w_p[3 + a]);  // bd
                r1_e[15 + a] <= DW'(w_p[9 + a]) - DW'(w_p[6 + a]);  // cd
            end
        end
    end

    // Stage 2: cross product terms of ac x ad and all component squares.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_cp[0] <= r1_e[4] * r1_e[8];
            r2_cp[1] <= r1_e[5] * r1_e[7];
            r2_cp[2] <= r1_e[5] * r1_e[6];
            r2_cp[3] <= r1_e[3] * r1_e[8];
            r2_cp[4] <= r1_e[3] * r1_e[7];
            r2_cp[5] <= r1_e[4] * r1_e[6];
            for (int i = 0; i < 18; i++) begin
                r2_sq[i] <= r1_e[i] * r1_e[i];
            end
            for (int a = 0; a < 3; a++) begin
                r2_ab[a] <= r1_e[a];
            end
        end
    end

    // Stage 3: cross product components and squared edge lengths.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r3_v[a]  <= tsq_pkg::VC_W'(r2_cp[2*a]) - tsq_pkg::VC_W'(r2_cp[2*a + 1]);
                r3_ab[a] <= r2_ab[a];
            end
            for (int e = 0; e < 6; e++) begin
                r3_el[e] <= tsq_pkg::EL_W'(r2_sq[3*e]) + tsq_pkg::EL_W'(r2_sq[3*e + 1])
                          + tsq_pkg::EL_W'(r2_sq[3*e + 2]);
            end
        end
    end

    // Stage 4: triple product in two slices per component, edge sum.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r4_pl[a] <= r3_ab[a] * $signed({1'b0, r3_v[a][tsq_pkg::VLO_W-1:0]});
                r4_ph[a] <= r3_ab[a] * $signed(r3_v[a][tsq_pkg::VC_W-1:tsq_pkg::VLO_W]);
            end
            r4_rsum <= tsq_pkg::RSUM_W'(r3_el[0]) + tsq_pkg::RSUM_W'(r3_el[1])
                     + tsq_pkg::RSUM_W'(r3_el[2]) + tsq_pkg::RSUM_W'(r3_el[3])
                     + tsq_pkg::RSUM_W'(r3_el[4]) + tsq_pkg::RSUM_W'(r3_el[5]);
        end
    end

    // Stage 5: recombine the slices.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r5_t[a] <= (tsq_pkg::t_tri'(r4_ph[a]) <<< tsq_pkg::VLO_W)
                         + tsq_pkg::t_tri'(r4_pl[a]);
            end
            r5_rsum <= r4_rsum;
        end
    end

    // Stage 6: six-times signed volume.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_vol  <= tsq_pkg::t_vol'(r5_t[0]) + tsq_pkg::t_vol'(r5_t[1])
                     + tsq_pkg::t_vol'(r5_t[2]);
            r6_rsum <= r5_rsum;
        end
    end

    // Stage 7: flat elements win over short edges; an empty edge sum is short.
    assign w_flat  = r6_vol[tsq_pkg::VOL_W-1]
                  || (r6_vol[tsq_pkg::VMAG_W-1:0] < tsq_pkg::VMAG_W'(r_vol_thr));
    assign w_short = (r6_rsum == '0) || (r6_rsum < tsq_pkg::RSUM_W'(r_len_thr));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_side.vmag <= r6_vol[tsq_pkg::VMAG_W-1:0];
            r7_side.rsum <= r6_rsum;
            if (w_flat) begin
                r7_side.status <= tsq_pkg::ST_FLAT;
            end else if (w_short) begin
                r7_side.status <= tsq_pkg::ST_SHORT;
            end else begin
                r7_side.status <= tsq_pkg::ST_OK;
            end
        end
    end

    // Square root of the scaled edge sum.
    tsq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r7_valid),
        .i_side  (r7_side),
        .o_valid (w_sq_valid),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // Denominator R * S in two slices, then recombined.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_dpl  <= tsq_pkg::DPL_W'(w_sq_side.rsum[tsq_pkg::RLO_W-1:0])
                     * tsq_pkg::DPL_W'(w_sq_root);
            r8_dph  <= tsq_pkg::DPH_W'(w_sq_side.rsum[tsq_pkg::RSUM_W-1:tsq_pkg::RLO_W])
                     * tsq_pkg::DPH_W'(w_sq_root);
            r8_side <= w_sq_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_den    <= (tsq_pkg::DEN_W'(r8_dph) << tsq_pkg::RLO_W)
                       + tsq_pkg::DEN_W'(r8_dpl);
            r9_vmag   <= r8_side.vmag;
            r9_status <= r8_side.status;
        end
    end

    // Quotient and output register.
    tsq_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r9_valid),
        .i_vmag    (r9_vmag),
        .i_den     (r9_den),
        .i_status  (r9_status),
        .o_valid   (w_out_valid),
        .o_quality (w_out_quality),
        .o_status  (w_out_status)
    );

    assign o_m_axis_tvalid = w_out_valid;
    assign o_m_axis_tdata  = w_out_quality;
    assign o_m_axis_tuser  = w_out_status;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Tetrahedron shape quality testbench
// Streams tetrahedra through the quality pipeline and checks each result,
// in order, against a predictor built from exact integer arithmetic.
// Thresholds are rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    logic [31:0]      quality;
    tsq_pkg::t_status status;
} t_quality_result;

// Scoreboard: holds predicted results and checks them as they come out.
class quality_scoreboard;
    t_quality_result pending[$];
    int              errors;

    function void note_request(t_quality_result r);
        pending.push_back(r);
    endfunction

    // One line per mismatch, and a count.
    task report(string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task check_result(logic [31:0] q, logic [1:0] st);
        t_quality_result e;
        if (pending.size() == 0) begin
            report($sformatf("result q=%h st=%0d with nothing pending", q, st));
            return;
        end
        e = pending.pop_front();
        if (q !== e.quality)
            report($sformatf("quality %h expected %h", q, e.quality));
        if (st !== e.status)
            report($sformatf("status %0d expected %0d", st, e.status));
    endtask
endclass

module tb_top;

    localparam int LATENCY   = 74;
    localparam int CYCLE_CAP = 400000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [287:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [31:0]  o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [tsq_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [tsq_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;

    tetrahedron_shape_quality dut (.*);

    always #10 i_clk = ~i_clk;

    quality_scoreboard sb = new();
    logic [47:0] vol_thr = 48'd1;
    logic [31:0] len_thr = 32'd1;
    int  cycles = 0;
    int  sink_idle_pct = 11;
    int  hold_off = 0;

    // Predicted quality of one tetrahedron under the current thresholds.
    function automatic t_quality_result predict_quality(logic [287:0] d);
        logic signed [24:0]  c[12];
        logic signed [25:0]  e[18];
        logic signed [127:0] vol, v1, v2, v3;
        logic [63:0]         rsum, root, bitv, rx;
        logic [127:0]        num, den, quo;
        t_quality_result     r;
        for (int i = 0; i < 12; i++)
            c[i] = $signed(d[i*24 +: 24]);
        // AB, AC, AD, BC, BD, CD.
        for (int k = 0; k < 3; k++) begin
            e[k]    = c[3+k] - c[k];
            e[3+k]  = c[6+k] - c[k];
            e[6+k]  = c[9+k] - c[k];
            e[9+k]  = c[6+k] - c[3+k];
            e[12+k] = c[9+k] - c[3+k];
            e[15+k] = c[9+k] - c[6+k];
        end
        v1 = 128'(e[4]) * 128'(e[8]) - 128'(e[5]) * 128'(e[7]);
        v2 = 128'(e[5]) * 128'(e[6]) - 128'(e[3]) * 128'(e[8]);
        v3 = 128'(e[3]) * 128'(e[7]) - 128'(e[4]) * 128'(e[6]);
        vol = 128'(e[0]) * v1 + 128'(e[1]) * v2 + 128'(e[2]) * v3;
        rsum = '0;
        for (int i = 0; i < 18; i++)
            rsum += 64'(64'(e[i]) * 64'(e[i]));
        r.quality = '0;
        if (vol < 0 || vol < $signed({80'd0, vol_thr})) begin
            r.status = tsq_pkg::ST_FLAT;
        end else if (rsum == 0 || rsum < {32'd0, len_thr}) begin
            r.status = tsq_pkg::ST_SHORT;
        end else begin
            // Bitwise integer square root of R * 2^10.
            rx = rsum << 10;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > rx) bitv >>= 2;
            while (bitv != 0) begin
                if (rx >= root + bitv) begin
                    rx -= root + bitv;
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            den = 128'(rsum) * 128'(root);
            num = 128'(vol) << 37;
            quo = num / den;
            r.quality = (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
            r.status = tsq_pkg::ST_OK;
        end
        return r;
    endfunction

    function automatic logic [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 1023)) - 512) << 12;
            default: return 24'($signed($urandom_range(0, 131071)) - 65536);
        endcase
    endfunction

    // Random tetrahedra at three coordinate scales; one in ten copies a_x into b_x.
    function automatic logic [287:0] rand_tet();
        logic [287:0] d;
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++)
            d[i*24 +: 24] = rand_coord(mode < 2 ? 0 : (mode < 5 ? 1 : 2));
        if (mode == 9)
            d[72 +: 24] = d[0 +: 24];
        return d;
    endfunction

    // Valid stays high between back-to-back requests and drops while idling.
    task automatic send_request(logic [287:0] d, bit may_idle);
        while (may_idle && $urandom_range(0, 99) < 11) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_request(predict_quality(d));
    endtask

    task automatic write_reg(logic [tsq_pkg::CFG_IDX_W-1:0] idx, logic [47:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == tsq_pkg::CFG_VOL_THR) vol_thr = val;
        else if (idx == tsq_pkg::CFG_LEN_THR) len_thr = val[31:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // Result side: random stalls, with a long hold-off when requested.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tetrahedron_shape_quality regression: fail");
            $finish;
        end
    end

    initial begin
        logic [287:0] d;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: regular, flat, inverted, coincident and extreme elements.
        d = '0;
        send_request(d, 0);
        d = '0; d[72 +: 24] = 24'h010000; d[168 +: 24] = 24'h010000;
        d[264 +: 24] = 24'h010000;
        send_request(d, 0);
        d[264 +: 24] = 24'hFF0000;
        send_request(d, 0);
        d = {12{24'h7FFFFF}};
        send_request(d, 0);
        d = {12{24'h800000}};
        send_request(d, 0);
        d = '0; d[72 +: 24] = 24'h7FFFFF; d[168 +: 24] = 24'h7FFFFF;
        d[264 +: 24] = 24'h7FFFFF; d[0 +: 24] = 24'h800000;
        d[24 +: 24] = 24'h800000; d[48 +: 24] = 24'h800000;
        send_request(d, 0);
        d = '0; d[72 +: 24] = 24'h000001; d[168 +: 24] = 24'h000001;
        d[264 +: 24] = 24'h000001;
        send_request(d, 0);
        d = '0; d[72 +: 24] = 24'h800000; d[168 +: 24] = 24'h800000;
        d[264 +: 24] = 24'h800000;
        send_request(d, 0);
        for (int i = 0; i < 8; i++) send_request(rand_tet(), 0);
        drain();

        // Thresholds at their extremes, and zero.
        write_reg(tsq_pkg::CFG_VOL_THR, 48'd0);
        write_reg(tsq_pkg::CFG_LEN_THR, 48'd0);
        d = '0; send_request(d, 0);
        d[72 +: 24] = 24'h000001; d[168 +: 24] = 24'h000001;
        d[264 +: 24] = 24'h000001; send_request(d, 0);
        for (int i = 0; i < 6; i++) send_request(rand_tet(), 0);
        drain();
        write_reg(tsq_pkg::CFG_VOL_THR, 48'hFFFF_FFFF_FFFF);
        write_reg(tsq_pkg::CFG_LEN_THR, 48'hFFFF_FFFF);
        write_reg(8'd7, 48'h1234);
        for (int i = 0; i < 6; i++) send_request(rand_tet(), 0);
        drain();
        write_reg(tsq_pkg::CFG_VOL_THR, 48'd0);
        for (int i = 0; i < 6; i++) send_request(rand_tet(), 0);
        drain();

        // Random phases under different thresholds.
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(tsq_pkg::CFG_VOL_THR,
                      ph == 0 ? 48'd1 : 48'({$urandom, $urandom} >> $urandom_range(4, 40)));
            write_reg(tsq_pkg::CFG_LEN_THR,
                      ph == 0 ? 48'd1 : 48'($urandom >> $urandom_range(0, 28)));
            sink_idle_pct = (ph == 2) ? 0 : 11;
            if (ph == 1) hold_off = 300;
            for (int i = 0; i < 240; i++)
                send_request(rand_tet(), ph != 2);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tetrahedron_shape_quality regression: pass");
        else
            $display("tetrahedron_shape_quality regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
